// ===== rtl/core/pse_pkg.sv =====
// Package for the postfix stack evaluator: field widths, character codes,
// operation, status and sequencer state types. No dependencies.
package pse_pkg;

	localparam int DEFAULT_STACK_DEPTH = 16;
	localparam int WORD_W   = 32;
	localparam int SYM_W    = 8;
	localparam int STATUS_W = 3;
	localparam int DEPTH_W  = 5;
	localparam int DIV_STEPS = 32;

	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [WORD_W-1:0] CH_ZERO = 32'd48;
	localparam logic [WORD_W-1:0] UNDER_VALUE = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_UNDER,
		ST_OVER,
		ST_DIVZ,
		ST_EMPTY
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP_R,
		S_POP_L,
		S_LOAD,
		S_EXEC,
		S_ABSR,
		S_DIV,
		S_DNEG,
		S_PUSH,
		S_FIN,
		S_EMIT
	} state_t;

	function automatic op_t decode_op(input logic [SYM_W-1:0] sym);
		op_t op;
		case (sym)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			default:  op = OP_PUSH;
		endcase
		return op;
	endfunction

endpackage

// ===== rtl/core/pse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/postfix_stack_evaluator_unit.sv =====
// Postfix expression evaluator: top level with sequencer, shared adder and divider.
// Depends on pse_pkg and pse_ram.
//
// The block takes one expression character per transfer and keeps a stack of up to
// STACK_DEPTH signed 32-bit values in a RAM with one write and one registered read
// port. An operand is accepted and then pushed. + - and * go through the accepting
// state, two pops through the single read port, a load state to catch the second
// read, an execute state and a push. / adds a radix-2 restoring divider that finds
// the quotient one bit per cycle over 32 steps, built on the one shared 32-bit
// adder, which also forms the operand magnitudes and the signed result. Division
// by zero skips the divider steps and pushes zero. A character marked as the end
// of the expression adds the FIN and EMIT states to read back the top of stack and
// load the result register; EMIT waits while an earlier result still waits there.
// item_stall is high whenever the sequencer is busy. The result register decouples
// the output: a new expression may start while a result waits, and only the next
// end-of-expression waits for the earlier result transfer. Errors are sticky per
// expression; the first one is reported.
module postfix_stack_evaluator_unit #(
	parameter int STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [pse_pkg::SYM_W-1:0]     symbol,
	input  logic                          end_of_expr,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [pse_pkg::WORD_W-1:0]    value,
	output logic [pse_pkg::STATUS_W-1:0]  status,
	output logic [pse_pkg::DEPTH_W-1:0]   depth
);

	import pse_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int CW = $clog2(DIV_STEPS);
	localparam logic [CW-1:0] DIV_LAST = CW'(DIV_STEPS - 1);

	// sequencer and control state
	state_t           state_q, state_d;
	logic [DW-1:0]    depth_q;
	status_t          sticky_q;
	logic             pend_q;      // a stack pop read was issued last cycle
	logic [CW-1:0]    cnt_q;
	logic             result_valid_q;

	// payload
	op_t              op_q;
	logic             eoe_q;
	logic [WORD_W-1:0] rhs_q, lhs_q, res_q;
	logic [WORD_W-1:0] rem_q, quo_q, mb_q;
	logic             neg_q;
	logic [WORD_W-1:0] value_q;
	status_t          status_q;
	logic [DEPTH_W-1:0] depth_out_q;

	// RAM port
	logic             wr_en, rd_en;
	logic [AW-1:0]    wr_addr, rd_addr;
	logic [WORD_W-1:0] wr_data, rd_data;

	// shared adder
	logic [WORD_W-1:0] add_a, add_b;
	logic             add_sub;
	logic [WORD_W:0]  add_res;
	logic [WORD_W-1:0] sum;
	logic             carry;

	// misc control
	logic             accept;
	logic             flag_en;
	status_t          flag_code;
	logic             emit_load;
	logic [DW-1:0]    depth_m1;
	logic             stack_empty, stack_full;
	logic [DW+4:0]    depth_wide;
	logic [WORD_W-1:0] prod;       // product wraps at the word width
	op_t              sym_op;

	assign sym_op      = decode_op(symbol);
	assign accept      = item_valid && (state_q == S_IDLE);
	assign depth_m1    = depth_q - DW'(1);
	assign stack_empty = (depth_q == '0);
	assign stack_full  = (depth_q >= DW'(STACK_DEPTH));
	assign depth_wide  = {5'b0, depth_q};
	assign prod        = lhs_q * rhs_q;

	assign add_res = {1'b0, add_a} + {1'b0, add_b ^ {WORD_W{add_sub}}} + {{WORD_W{1'b0}}, add_sub};
	assign sum     = add_res[WORD_W-1:0];
	assign carry   = add_res[WORD_W];   // set on subtract means a >= b

	pse_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (sym_op == OP_PUSH) ? S_PUSH : S_POP_R;
				end
			end
			S_POP_R: state_d = S_POP_L;
			S_POP_L: state_d = S_LOAD;
			S_LOAD:  state_d = S_EXEC;
			S_EXEC: begin
				state_d = (op_q == OP_DIV && rhs_q != '0) ? S_ABSR : S_PUSH;
			end
			S_ABSR: state_d = S_DIV;
			S_DIV:  state_d = (cnt_q == DIV_LAST) ? S_DNEG : S_DIV;
			S_DNEG: state_d = S_PUSH;
			S_PUSH: state_d = eoe_q ? S_FIN : S_IDLE;
			S_FIN:  state_d = S_EMIT;
			S_EMIT: begin
				if (!result_valid_q || !result_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: stall, RAM port, shared adder operands, error flags, result load
	always_comb begin
		item_stall = (state_q != S_IDLE);
		wr_en      = 1'b0;
		wr_addr    = depth_q[AW-1:0];
		wr_data    = res_q;
		rd_en      = 1'b0;
		rd_addr    = depth_m1[AW-1:0];
		add_a      = '0;
		add_b      = '0;
		add_sub    = 1'b0;
		flag_en    = 1'b0;
		flag_code  = ST_OK;
		emit_load  = 1'b0;
		case (state_q)
			S_POP_R, S_POP_L: begin
				if (stack_empty) begin
					flag_en   = 1'b1;
					flag_code = ST_UNDER;
				end else begin
					rd_en = 1'b1;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_SUB: begin
						add_a   = lhs_q;
						add_b   = rhs_q;
						add_sub = 1'b1;
					end
					OP_DIV: begin
						// magnitude of the dividend
						add_b   = lhs_q;
						add_sub = 1'b1;
						if (rhs_q == '0) begin
							flag_en   = 1'b1;
							flag_code = ST_DIVZ;
						end
					end
					default: begin
						add_a = lhs_q;
						add_b = rhs_q;
					end
				endcase
			end
			S_ABSR: begin
				add_b   = rhs_q;
				add_sub = 1'b1;
			end
			S_DIV: begin
				add_a   = {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
				add_b   = mb_q;
				add_sub = 1'b1;
			end
			S_DNEG: begin
				add_b   = quo_q;
				add_sub = 1'b1;
			end
			S_PUSH: begin
				if (stack_full) begin
					flag_en   = 1'b1;
					flag_code = ST_OVER;
				end else begin
					wr_en = 1'b1;
				end
			end
			S_FIN: begin
				rd_en = !stack_empty;
			end
			S_EMIT: begin
				emit_load = !result_valid_q || !result_stall;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			depth_q        <= '0;
			sticky_q       <= ST_OK;
			pend_q         <= 1'b0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= (state_q == S_POP_R || state_q == S_POP_L) && !stack_empty;

			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end

			if (emit_load) begin
				depth_q  <= '0;
				sticky_q <= ST_OK;
			end else begin
				if ((state_q == S_POP_R || state_q == S_POP_L) && !stack_empty) begin
					depth_q <= depth_m1;
				end else if (wr_en) begin
					depth_q <= depth_q + DW'(1);
				end
				if (flag_en && sticky_q == ST_OK) begin
					sticky_q <= flag_code;
				end
			end

			if (emit_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= sym_op;
					eoe_q <= end_of_expr;
					res_q <= {{(WORD_W-SYM_W){1'b0}}, symbol} - CH_ZERO;
				end
			end
			S_POP_R: begin
				rhs_q <= UNDER_VALUE;
			end
			S_POP_L: begin
				if (pend_q) begin
					rhs_q <= rd_data;
				end
				lhs_q <= UNDER_VALUE;
			end
			S_LOAD: begin
				if (pend_q) begin
					lhs_q <= rd_data;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_MUL: res_q <= prod;
					OP_DIV: begin
						res_q <= '0;
						rem_q <= '0;
						quo_q <= lhs_q[WORD_W-1] ? sum : lhs_q;
						neg_q <= lhs_q[WORD_W-1] ^ rhs_q[WORD_W-1];
					end
					default: res_q <= sum;
				endcase
			end
			S_ABSR: begin
				mb_q <= rhs_q[WORD_W-1] ? sum : rhs_q;
			end
			S_DIV: begin
				// restoring step: keep the difference when it did not borrow
				rem_q <= carry ? sum : add_a;
				quo_q <= {quo_q[WORD_W-2:0], carry};
			end
			S_DNEG: begin
				res_q <= neg_q ? sum : quo_q;
			end
			S_EMIT: begin
				if (emit_load) begin
					value_q     <= stack_empty ? '0 : rd_data;
					status_q    <= (stack_empty && sticky_q == ST_OK) ? ST_EMPTY : sticky_q;
					depth_out_q <= (depth_wide > (DW+5)'(31)) ? DEPTH_W'(31)
					                                          : depth_wide[DEPTH_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign status       = status_q;
	assign depth        = depth_out_q;

endmodule
